FILE: sv/change_triggered_min_max_aggregator_core_assert.svh
// assertion macros for the change-triggered min/max aggregator
`ifndef CHANGE_TRIGGERED_MIN_MAX_AGGREGATOR_CORE_ASSERT_SVH
`define CHANGE_TRIGGERED_MIN_MAX_AGGREGATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CTMM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");
`define CTMM_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: reset assertion failed");
`else
`define CTMM_ASSERT(lbl, clk, rstn, prop)
`define CTMM_ASSERT_RST(lbl, clk, prop)
`endif
`endif

FILE: sv/ctmm_pkg.sv
// shared types, constants and the saturating add function of the min/max aggregator
package ctmm_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int TIME_W    = 32;
  localparam int VAL_W     = 32;
  localparam int SUM_W     = 56;
  localparam int OUT_CNT_W = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_TRIGGER    = 2'd3;

  typedef enum logic [1:0] {
    REQ_SAMPLE    = 2'd0,
    REQ_FAIL      = 2'd1,
    REQ_CLR_STORE = 2'd2,
    REQ_CLR_ALL   = 2'd3
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0]  range_threshold;
    logic [TIME_W-1:0] min_period_ms;
    logic [TIME_W-1:0] max_period_ms;
    logic              self_trigger;
  } cfg_t;

  typedef struct packed {
    req_t                       req_type;
    logic signed [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]          now_ms;
    logic                       commit;
  } item_t;

  typedef struct packed {
    logic                       store_flag;
    logic [OUT_CNT_W-1:0]       store_count;
    logic signed [SUM_W-1:0]    store_sum;
    logic signed [SAMPLE_W-1:0] store_min;
    logic signed [SAMPLE_W-1:0] store_max;
    logic [OUT_CNT_W-1:0]       accum_count;
  } result_t;

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] a,
    input logic signed [SUM_W-1:0] b
  );
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? SUM_MIN : SUM_MAX;
    end
    return s[SUM_W-1:0];
  endfunction

endpackage

FILE: sv/ctmm_update.sv
// accumulator and store state with the per-word update logic
`include "change_triggered_min_max_aggregator_core_assert.svh"
module ctmm_update #(
  parameter int SAMPLE_BITS = 32,
  parameter int COUNT_BITS  = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  ctmm_pkg::item_t   item,
  input  ctmm_pkg::cfg_t    cfg,
  output ctmm_pkg::result_t res
);
  import ctmm_pkg::*;

  localparam int CMP_W = VAL_W + 1;
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  function automatic logic [COUNT_BITS-1:0] cnt_add(
    input logic [COUNT_BITS-1:0] a,
    input logic [COUNT_BITS-1:0] b
  );
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_BITS] ? CNT_MAX : s[COUNT_BITS-1:0];
  endfunction

  logic signed [SUM_W-1:0]       acc_sum_r, acc_sum_nxt, sto_sum_r, sto_sum_nxt;
  logic [COUNT_BITS-1:0]         acc_count_r, acc_count_nxt, sto_count_r, sto_count_nxt;
  logic signed [SAMPLE_BITS-1:0] acc_max_r, acc_max_nxt, acc_min_r, acc_min_nxt;
  logic signed [SAMPLE_BITS-1:0] sto_max_r, sto_max_nxt, sto_min_r, sto_min_nxt;
  logic [TIME_W-1:0]             win_start_r, win_start_nxt;

  logic signed [SAMPLE_BITS-1:0] smp, emax, emin, mmax, mmin;
  logic signed [SUM_W-1:0]       smp_ext, msum;
  logic [COUNT_BITS-1:0]         mcount;
  logic [SAMPLE_BITS:0]          span;
  logic [TIME_W-1:0]             age;
  logic                          wide, raise, merge, flag;

  assign smp     = item.sample[SAMPLE_BITS-1:0];
  assign smp_ext = SUM_W'(smp);
  assign emax    = (acc_max_r > smp) ? acc_max_r : smp;
  assign emin    = (acc_min_r < smp) ? acc_min_r : smp;
  assign span    = {emax[SAMPLE_BITS-1], emax} - {emin[SAMPLE_BITS-1], emin};
  assign wide    = CMP_W'(span) >= CMP_W'(cfg.range_threshold);
  assign age     = item.now_ms - win_start_r;
  assign raise   = ((age > cfg.max_period_ms) || wide) && (age > cfg.min_period_ms);

  // pending request never outlives a sample poll, so only commit merges on a failed poll
  assign merge = ((item.req_type == REQ_SAMPLE) && raise && cfg.self_trigger) ||
                 (((item.req_type == REQ_SAMPLE) || (item.req_type == REQ_FAIL)) &&
                  item.commit);

  assign msum   = sat_add(sto_sum_r, acc_sum_r);
  assign mcount = cnt_add(sto_count_r, acc_count_r);
  assign mmax   = (acc_max_r > sto_max_r) ? acc_max_r : sto_max_r;
  assign mmin   = (acc_min_r < sto_min_r) ? acc_min_r : sto_min_r;

  always_comb begin
    acc_sum_nxt   = acc_sum_r;
    acc_count_nxt = acc_count_r;
    acc_max_nxt   = acc_max_r;
    acc_min_nxt   = acc_min_r;
    win_start_nxt = win_start_r;
    sto_sum_nxt   = sto_sum_r;
    sto_count_nxt = sto_count_r;
    sto_max_nxt   = sto_max_r;
    sto_min_nxt   = sto_min_r;
    flag          = 1'b0;
    unique case (item.req_type)
      REQ_SAMPLE: begin
        flag = raise;
        if (merge) begin
          sto_sum_nxt   = msum;
          sto_count_nxt = mcount;
          sto_max_nxt   = mmax;
          sto_min_nxt   = mmin;
        end
        if (merge || (acc_count_r == '0)) begin
          win_start_nxt = item.now_ms;
          acc_max_nxt   = smp;
          acc_min_nxt   = smp;
        end else begin
          acc_max_nxt = emax;
          acc_min_nxt = emin;
        end
        acc_sum_nxt   = merge ? smp_ext : sat_add(acc_sum_r, smp_ext);
        acc_count_nxt = merge ? CNT_ONE : cnt_add(acc_count_r, CNT_ONE);
      end
      REQ_FAIL: begin
        if (merge) begin
          sto_sum_nxt   = msum;
          sto_count_nxt = mcount;
          sto_max_nxt   = mmax;
          sto_min_nxt   = mmin;
          acc_sum_nxt   = '0;
          acc_count_nxt = '0;
          acc_max_nxt   = S_MIN;
          acc_min_nxt   = S_MAX;
        end
      end
      REQ_CLR_STORE: begin
        sto_sum_nxt   = '0;
        sto_count_nxt = '0;
        sto_max_nxt   = S_MIN;
        sto_min_nxt   = S_MAX;
      end
      REQ_CLR_ALL: begin
        acc_sum_nxt   = '0;
        acc_count_nxt = '0;
        acc_max_nxt   = S_MIN;
        acc_min_nxt   = S_MAX;
        win_start_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_sum_r   <= '0;
      acc_count_r <= '0;
      acc_max_r   <= S_MIN;
      acc_min_r   <= S_MAX;
      win_start_r <= '0;
      sto_sum_r   <= '0;
      sto_count_r <= '0;
      sto_max_r   <= S_MIN;
      sto_min_r   <= S_MAX;
    end else if (fire) begin
      acc_sum_r   <= acc_sum_nxt;
      acc_count_r <= acc_count_nxt;
      acc_max_r   <= acc_max_nxt;
      acc_min_r   <= acc_min_nxt;
      win_start_r <= win_start_nxt;
      sto_sum_r   <= sto_sum_nxt;
      sto_count_r <= sto_count_nxt;
      sto_max_r   <= sto_max_nxt;
      sto_min_r   <= sto_min_nxt;
    end
  end

  assign res.store_flag  = flag;
  assign res.store_count = OUT_CNT_W'(sto_count_nxt);
  assign res.store_sum   = sto_sum_nxt;
  assign res.store_min   = SAMPLE_W'(sto_min_nxt);
  assign res.store_max   = SAMPLE_W'(sto_max_nxt);
  assign res.accum_count = OUT_CNT_W'(acc_count_nxt);

  `CTMM_ASSERT(a_sample_fills, clk, rst_n, fire && (item.req_type == REQ_SAMPLE) |=> acc_count_r != '0)
  `CTMM_ASSERT(a_clear_all, clk, rst_n, fire && (item.req_type == REQ_CLR_ALL) |=> (acc_count_r == '0) && (acc_sum_r == '0))
  `CTMM_ASSERT(a_acc_order, clk, rst_n, (acc_count_r != '0) |-> acc_max_r >= acc_min_r)
  `CTMM_ASSERT(a_idle_hold, clk, rst_n, !fire |=> $stable(sto_sum_r) && $stable(acc_count_r))

endmodule

FILE: sv/change_triggered_min_max_aggregator_core.sv
// throughput: one word per cycle while the output is not stalled by out_ready
// an input register feeds one update stage that loads the result register directly
// in_ready falls only while both the input and result registers hold words
// reset: synchronous active low, clears accumulator, store and handshake state
// config resets to zero thresholds and periods with self trigger enabled
`include "change_triggered_min_max_aggregator_core_assert.svh"
module change_triggered_min_max_aggregator_core #(
  parameter int SAMPLE_BITS = 32,
  parameter int COUNT_BITS  = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [ctmm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ctmm_pkg::VAL_W-1:0]            cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            in_req_type,
  input  logic signed [ctmm_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic [ctmm_pkg::TIME_W-1:0]           in_now_ms,
  input  logic                                  in_commit,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_store_flag,
  output logic [ctmm_pkg::OUT_CNT_W-1:0]        out_store_count,
  output logic signed [ctmm_pkg::SUM_W-1:0]     out_store_sum,
  output logic signed [ctmm_pkg::SAMPLE_W-1:0]  out_store_min,
  output logic signed [ctmm_pkg::SAMPLE_W-1:0]  out_store_max,
  output logic [ctmm_pkg::OUT_CNT_W-1:0]        out_accum_count
);
  import ctmm_pkg::*;

  cfg_t    cfg_r;
  item_t   s1_item_r;
  logic    s1_valid_r, out_valid_r;
  result_t out_res_r, res;
  logic    s1_fire;

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.range_threshold <= '0;
      cfg_r.min_period_ms   <= '0;
      cfg_r.max_period_ms   <= '0;
      cfg_r.self_trigger    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RANGE_THRESHOLD: cfg_r.range_threshold <= cfg_wdata;
        CFG_MIN_PERIOD:      cfg_r.min_period_ms   <= cfg_wdata;
        CFG_MAX_PERIOD:      cfg_r.max_period_ms   <= cfg_wdata;
        CFG_SELF_TRIGGER:    cfg_r.self_trigger    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.req_type <= req_t'(in_req_type);
      s1_item_r.sample   <= in_sample;
      s1_item_r.now_ms   <= in_now_ms;
      s1_item_r.commit   <= in_commit;
    end
  end

  ctmm_update #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_update (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (s1_fire),
    .item  (s1_item_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_store_flag  = out_res_r.store_flag;
  assign out_store_count = out_res_r.store_count;
  assign out_store_sum   = out_res_r.store_sum;
  assign out_store_min   = out_res_r.store_min;
  assign out_store_max   = out_res_r.store_max;
  assign out_accum_count = out_res_r.accum_count;

  `CTMM_ASSERT(a_fire_loads, clk, rst_n, s1_fire |=> out_valid_r)
  `CTMM_ASSERT(a_stall_cause, clk, rst_n, s1_valid_r && !s1_fire |-> out_valid_r && !out_ready)
  `CTMM_ASSERT(a_no_drop, clk, rst_n, s1_valid_r && !s1_fire |=> s1_valid_r)
  `CTMM_ASSERT_RST(a_reset_empty, clk, !rst_n |=> !out_valid_r && !s1_valid_r)

endmodule

FILE: tb/sv/change_triggered_min_max_aggregator_core_checker.sv
// checker for the min/max aggregator: predicts each result word and compares it on the output
module change_triggered_min_max_aggregator_core_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [ctmm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ctmm_pkg::VAL_W-1:0]            cfg_wdata,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic [1:0]                            in_req_type,
  input  logic signed [ctmm_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic [ctmm_pkg::TIME_W-1:0]           in_now_ms,
  input  logic                                  in_commit,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic                                  out_store_flag,
  input  logic [ctmm_pkg::OUT_CNT_W-1:0]        out_store_count,
  input  logic signed [ctmm_pkg::SUM_W-1:0]     out_store_sum,
  input  logic signed [ctmm_pkg::SAMPLE_W-1:0]  out_store_min,
  input  logic signed [ctmm_pkg::SAMPLE_W-1:0]  out_store_max,
  input  logic [ctmm_pkg::OUT_CNT_W-1:0]        out_accum_count,
  output int                                    mismatches,
  output int                                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import ctmm_pkg::*;

  localparam logic signed [SAMPLE_W-1:0] SMP_TOP = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SMP_BOT = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [OUT_CNT_W-1:0]       CNT_TOP = '1;

  cfg_t                       regs;
  logic signed [SUM_W-1:0]    win_sum, bank_sum;
  logic [OUT_CNT_W-1:0]       win_count, bank_count;
  logic signed [SAMPLE_W-1:0] win_hi, win_lo, bank_hi, bank_lo;
  logic [TIME_W-1:0]          win_start;
  logic                       win_req;
  result_t                    expected_words[$];

  function automatic logic signed [SUM_W-1:0] clamp_sum(logic signed [SUM_W-1:0] a,
                                                        logic signed [SUM_W-1:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > longint'(SUM_MAX)) return SUM_MAX;
    if (s < longint'(SUM_MIN)) return SUM_MIN;
    return s[SUM_W-1:0];
  endfunction

  function automatic logic [OUT_CNT_W-1:0] clamp_count(logic [OUT_CNT_W-1:0] a,
                                                       logic [OUT_CNT_W-1:0] b);
    logic [OUT_CNT_W:0] s;
    s = a + b;
    return s[OUT_CNT_W] ? CNT_TOP : s[OUT_CNT_W-1:0];
  endfunction

  function automatic void clear_window();
    win_sum   = '0;
    win_count = '0;
    win_hi    = SMP_BOT;
    win_lo    = SMP_TOP;
  endfunction

  function automatic void clear_bank();
    bank_sum   = '0;
    bank_count = '0;
    bank_hi    = SMP_BOT;
    bank_lo    = SMP_TOP;
  endfunction

  function automatic void fold_window();
    bank_sum   = clamp_sum(bank_sum, win_sum);
    bank_count = clamp_count(bank_count, win_count);
    if (win_hi > bank_hi) bank_hi = win_hi;
    if (win_lo < bank_lo) bank_lo = win_lo;
    clear_window();
  endfunction

  function automatic result_t aggregate_word(item_t w);
    logic signed [SAMPLE_W-1:0] smp, hi, lo;
    logic [TIME_W-1:0]          age;
    logic                       raised;
    result_t                    r;
    smp    = w.sample;
    raised = win_req;
    case (w.req_type)
      REQ_SAMPLE: begin
        hi  = (win_hi > smp) ? win_hi : smp;
        lo  = (win_lo < smp) ? win_lo : smp;
        age = w.now_ms - win_start;
        if ((age > regs.max_period_ms ||
             longint'(hi) - longint'(lo) >= longint'(regs.range_threshold)) &&
            age > regs.min_period_ms) win_req = 1'b1;
        raised = win_req;
        if ((win_req && regs.self_trigger) || w.commit) fold_window();
        win_req = 1'b0;
        if (win_count == '0) begin
          win_start = w.now_ms;
          win_hi    = smp;
          win_lo    = smp;
        end else begin
          win_hi = hi;
          win_lo = lo;
        end
        win_sum   = clamp_sum(win_sum, $signed({{(SUM_W-SAMPLE_W){smp[SAMPLE_W-1]}}, smp}));
        win_count = clamp_count(win_count, OUT_CNT_W'(1));
      end
      REQ_FAIL: begin
        if ((win_req && regs.self_trigger) || w.commit) fold_window();
      end
      REQ_CLR_STORE: begin
        clear_bank();
      end
      default: begin
        clear_window();
        win_start = '0;
        win_req   = 1'b0;
        raised    = 1'b0;
      end
    endcase
    r.store_flag  = raised;
    r.store_count = bank_count;
    r.store_sum   = bank_sum;
    r.store_min   = bank_lo;
    r.store_max   = bank_hi;
    r.accum_count = win_count;
    return r;
  endfunction

  function automatic void check_field(string label, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
      mismatches++;
    end
  endfunction

  initial mismatches = 0;

  always @(posedge clk) begin : watch
    item_t   w;
    result_t want;
    if (!rst_n) begin
      regs              = '0;
      regs.self_trigger = 1'b1;
      clear_window();
      clear_bank();
      win_start = '0;
      win_req   = 1'b0;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RANGE_THRESHOLD: regs.range_threshold = cfg_wdata;
          CFG_MIN_PERIOD:      regs.min_period_ms   = cfg_wdata;
          CFG_MAX_PERIOD:      regs.max_period_ms   = cfg_wdata;
          CFG_SELF_TRIGGER:    regs.self_trigger    = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        w.req_type = req_t'(in_req_type);
        w.sample   = in_sample;
        w.now_ms   = in_now_ms;
        w.commit   = in_commit;
        expected_words.push_back(aggregate_word(w));
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result word with nothing expected", $time);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          check_field("store_flag", want.store_flag, out_store_flag);
          check_field("store_count", want.store_count, out_store_count);
          check_field("store_sum", want.store_sum, out_store_sum);
          check_field("store_min", want.store_min, out_store_min);
          check_field("store_max", want.store_max, out_store_max);
          check_field("accum_count", want.accum_count, out_accum_count);
        end
      end
    end
    outstanding = expected_words.size();
  end

endmodule

FILE: tb/sv/change_triggered_min_max_aggregator_core_test.sv
// top of the min/max aggregator testbench: clock, reset, stimulus, idling and verdict
module change_triggered_min_max_aggregator_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ctmm_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int BURST_ITEMS = 120;

  logic                       clk;
  logic                       rst_n       = 1'b0;
  logic                       cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index   = '0;
  logic [VAL_W-1:0]           cfg_wdata   = '0;
  logic                       in_valid    = 1'b0;
  logic                       in_ready;
  logic [1:0]                 in_req_type = '0;
  logic signed [SAMPLE_W-1:0] in_sample   = '0;
  logic [TIME_W-1:0]          in_now_ms   = '0;
  logic                       in_commit   = 1'b0;
  logic                       out_valid;
  logic                       out_ready   = 1'b0;
  logic                       out_store_flag;
  logic [OUT_CNT_W-1:0]       out_store_count;
  logic signed [SUM_W-1:0]    out_store_sum;
  logic signed [SAMPLE_W-1:0] out_store_min;
  logic signed [SAMPLE_W-1:0] out_store_max;
  logic [OUT_CNT_W-1:0]       out_accum_count;

  int mismatches;
  int outstanding;
  int send_idle    = 14;
  int recv_idle    = 57;
  bit hold_request = 1'b0;
  int hold_left    = 0;
  int idle_cycles  = 0;

  change_triggered_min_max_aggregator_core i_dut (.*);

  change_triggered_min_max_aggregator_core_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic offer_word(req_t kind, logic signed [SAMPLE_W-1:0] value,
                            logic [TIME_W-1:0] stamp, logic push);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_sample   <= value;
    in_now_ms   <= stamp;
    in_commit   <= push;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_settings(logic [VAL_W-1:0] thr, logic [VAL_W-1:0] lo_p,
                                  logic [VAL_W-1:0] hi_p, logic trig);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RANGE_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_index <= CFG_MIN_PERIOD;
    cfg_wdata <= lo_p;
    @(posedge clk);
    cfg_index <= CFG_MAX_PERIOD;
    cfg_wdata <= hi_p;
    @(posedge clk);
    cfg_index <= CFG_SELF_TRIGGER;
    cfg_wdata <= {{(VAL_W-1){1'b0}}, trig};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [VAL_W-1:0]           thr, lo_p, hi_p;
    logic [TIME_W-1:0]          stamp;
    logic signed [SAMPLE_W-1:0] level, value;
    int                         spread, roll;
    req_t                       kind;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: empty commit, extremes, wide range
    offer_word(REQ_FAIL, '0, '0, 1'b1);
    offer_word(REQ_SAMPLE, 32'sh7FFFFFFF, 32'd0, 1'b0);
    offer_word(REQ_SAMPLE, 32'sh80000000, 32'd1, 1'b0);
    offer_word(REQ_CLR_STORE, 32'shFFFFFFFF, 32'hFFFFFFFF, 1'b1);
    settle();

    program_settings(32'd100, 32'd5, 32'd1000, 1'b1);
    offer_word(REQ_SAMPLE, 32'sd10, 32'd1000, 1'b0);
    offer_word(REQ_SAMPLE, 32'sd50, 32'd1003, 1'b0);
    offer_word(REQ_SAMPLE, 32'sd200, 32'd1004, 1'b0);
    offer_word(REQ_SAMPLE, 32'sd0, 32'd1010, 1'b0);
    offer_word(REQ_FAIL, 32'sh7FFFFFFF, 32'd1011, 1'b0);
    offer_word(REQ_FAIL, 32'sh80000000, 32'd1012, 1'b1);
    offer_word(REQ_SAMPLE, -32'sd7, 32'd1013, 1'b1);
    offer_word(REQ_CLR_ALL, 32'shFFFFFFFF, 32'hFFFFFFFF, 1'b1);
    offer_word(REQ_SAMPLE, 32'sd3, 32'hFFFFFFFE, 1'b0);
    offer_word(REQ_SAMPLE, 32'sd4, 32'd3, 1'b0);
    offer_word(REQ_SAMPLE, 32'sd5, 32'd4, 1'b0);
    offer_word(REQ_CLR_STORE, 32'sd0, 32'd5, 1'b0);
    settle();

    // never old enough, no self trigger
    program_settings(32'd0, 32'hFFFFFFFF, 32'd0, 1'b0);
    offer_word(REQ_SAMPLE, -32'sd5, 32'd0, 1'b0);
    offer_word(REQ_SAMPLE, 32'sd5, 32'd100, 1'b0);
    offer_word(REQ_FAIL, 32'sd0, 32'd200, 1'b1);
    offer_word(REQ_SAMPLE, 32'sd9, 32'd300, 1'b1);
    settle();

    program_settings(32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF, 1'b1);
    offer_word(REQ_SAMPLE, 32'sh80000000, 32'd0, 1'b0);
    offer_word(REQ_SAMPLE, 32'sh7FFFFFFF, 32'hFFFFFFFF, 1'b0);
    offer_word(REQ_CLR_ALL, 32'sd0, 32'd0, 1'b0);
    offer_word(REQ_FAIL, 32'sd1, 32'd1, 1'b0);

    for (int m = 0; m < 3; m++) begin
      send_idle = (m == 0) ? 14 : (m == 1) ? 57 : 0;
      recv_idle = (m == 0) ? 57 : (m == 1) ? 14 : 0;
      for (int b = 0; b < 2; b++) begin
        settle();
        case ($urandom_range(4))
          0: thr = '0;
          1: thr = $urandom_range(2000);
          2: thr = $urandom_range(100000);
          3: thr = '1;
          default: thr = $urandom();
        endcase
        case ($urandom_range(3))
          0: lo_p = '0;
          1: lo_p = $urandom_range(100);
          2: lo_p = $urandom_range(1000);
          default: lo_p = '1;
        endcase
        case ($urandom_range(3))
          0: hi_p = '0;
          1: hi_p = $urandom_range(200);
          2: hi_p = $urandom_range(3000);
          default: hi_p = '1;
        endcase
        program_settings(thr, lo_p, hi_p, 1'($urandom_range(1)));
        if (m == 2 && b == 0) hold_request = 1'b1;

        stamp = ($urandom_range(3) == 0) ? 32'hFFFFFFFF - $urandom_range(500) : $urandom();
        level = $urandom();
        case ($urandom_range(3))
          0: spread = $urandom_range(15);
          1: spread = $urandom_range(2000);
          default: spread = $urandom_range(1 << 20);
        endcase
        repeat (BURST_ITEMS) begin
          roll = $urandom_range(99);
          kind = (roll < 72) ? REQ_SAMPLE : (roll < 84) ? REQ_FAIL :
                 (roll < 92) ? REQ_CLR_STORE : REQ_CLR_ALL;
          stamp = stamp + (($urandom_range(15) == 0) ? $urandom_range(5000)
                                                      : $urandom_range(40));
          if ($urandom_range(39) == 0) level = $urandom();
          if ($urandom_range(19) == 0) begin
            case ($urandom_range(3))
              0: value = 32'sh7FFFFFFF;
              1: value = 32'sh80000000;
              default: value = $urandom();
            endcase
          end else begin
            value = level + ($urandom_range(2 * spread) - spread);
          end
          offer_word(kind, value, ($urandom_range(29) == 0) ? $urandom() : stamp,
                     $urandom_range(9) == 0);
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

endmodule
